[rtl/core/bpf_pkg.sv]
// Shared constants, types and register codes for the biquad peaking filter.
package bpf_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CHANNELS    = 2;
    localparam int CHAN_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int COEF_W      = 32;
    localparam int FRAC_BITS   = 24;
    localparam int PROD_W      = COEF_W + SAMPLE_BITS;
    localparam int ACC_W       = PROD_W + 3;

    localparam int DATA_W      = 32;
    localparam int REG_COUNT   = 5;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int ADDR_W      = REG_IDX_W + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX_ACC =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN_ACC =
        ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coefs;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CHAN_W-1:0]             chan;
    } t_item;

endpackage

[rtl/core/biquad_peaking_filter.sv]
// Top level of the direct form I biquad peaking filter with per-channel history.
//
// Each input transaction carries one signed sample and a channel tag; each
// yields exactly one output transaction, in input order, with the filtered
// sample y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 (Q8.24 coefficients, exact
// sum, round half up, saturate to the sample width) and a clip flag. The
// stored history keeps the saturated output. Rate: one sample per clock when
// consecutive samples alternate channels and the output is not stalled; a
// sample that follows one of the same channel waits until the loop from the
// product stage through the sum stage has written that channel's history.
// Each result goes from the input queue through the product stage into the
// output register. A two-entry input queue separates the front from the
// datapath, and the output register lets new input transactions through while
// a result waits. Coefficients come from the APB-style port (b0, b1, b2, a1,
// a2 at byte offsets 0x00 to 0x10); write them only while the filter is idle.
module biquad_peaking_filter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [bpf_pkg::ADDR_W-1:0]             paddr,
    input  logic [bpf_pkg::DATA_W-1:0]             pwdata,
    output logic [bpf_pkg::DATA_W-1:0]             prdata,
    output logic                                   pready,
    // sample input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [bpf_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic                                   i_chan,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [bpf_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                                   o_clipped
);
    import bpf_pkg::*;

    t_coefs coefs;
    logic   q_valid;
    t_item  q_item;
    logic   q_pop;

    // coefficient registers
    bpf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (coefs)
    );

    // front: accept and queue
    bpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .i_chan      (i_chan),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    // back: multiply, sum, saturate, update history, hold result
    bpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coefs      (coefs),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

endmodule

[rtl/core/bpf_regs.sv]
// Coefficient register file behind the APB-style configuration port.
module bpf_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpf_pkg::ADDR_W-1:0]  paddr,
    input  logic [bpf_pkg::DATA_W-1:0]  pwdata,
    output logic [bpf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output bpf_pkg::t_coefs             o_coefs
);
    import bpf_pkg::*;

    t_coefs   r_coefs;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_coefs = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= COEF_ONE;
            r_coefs.b1 <= COEF_ZERO;
            r_coefs.b2 <= COEF_ZERO;
            r_coefs.a1 <= COEF_ZERO;
            r_coefs.a2 <= COEF_ZERO;
        end else if (wr_en) begin
            unique case (idx)
                REG_B0:  r_coefs.b0 <= COEF_W'(pwdata);
                REG_B1:  r_coefs.b1 <= COEF_W'(pwdata);
                REG_B2:  r_coefs.b2 <= COEF_W'(pwdata);
                REG_A1:  r_coefs.a1 <= COEF_W'(pwdata);
                REG_A2:  r_coefs.a2 <= COEF_W'(pwdata);
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_B0:  prdata = DATA_W'(r_coefs.b0);
            REG_B1:  prdata = DATA_W'(r_coefs.b1);
            REG_B2:  prdata = DATA_W'(r_coefs.b2);
            REG_A1:  prdata = DATA_W'(r_coefs.a1);
            REG_A2:  prdata = DATA_W'(r_coefs.a2);
            default: prdata = '0;
        endcase
    end

endmodule

[rtl/core/bpf_front.sv]
// Input side: accepts samples, maps the channel tag and queues the items.
module bpf_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [bpf_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic                              i_chan,
    output logic                              o_q_valid,
    output bpf_pkg::t_item                    o_q_item,
    input  logic                              i_q_pop
);
    import bpf_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              push;
    t_item             item_in;

    // chan modulo CHANNELS: a one-bit tag is already in range unless there
    // is only a single channel.
    assign item_in.sample = i_sample_in;
    assign item_in.chan   = (CHANNELS > 1) ? CHAN_W'(i_chan) : '0;

    assign o_in_stall = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid & ~o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        priority if (push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item_in;
        end
    end

endmodule

[rtl/core/bpf_back.sv]
// Filter datapath: product stage, sum/round/saturate stage, history, output register.
module bpf_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bpf_pkg::t_coefs                        i_coefs,
    input  logic                                   i_q_valid,
    input  bpf_pkg::t_item                         i_q_item,
    output logic                                   o_q_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [bpf_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                                   o_clipped
);
    import bpf_pkg::*;

    // per-channel history
    logic signed [SAMPLE_BITS-1:0] r_in1  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_in2  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_out1 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_out2 [CHANNELS];

    // product stage
    logic                          r_m_valid;
    logic [CHAN_W-1:0]             r_m_chan;
    logic signed [SAMPLE_BITS-1:0] r_m_x;
    logic signed [PROD_W-1:0]      r_m_p0, r_m_p1, r_m_p2, r_m_p3, r_m_p4;
    logic signed [PROD_W-1:0]      n_m_p0, n_m_p1, n_m_p2, n_m_p3, n_m_p4;

    // output register
    logic                          r_o_valid, n_o_valid;
    logic signed [SAMPLE_BITS-1:0] r_o_sample;
    logic                          r_o_clip;

    logic                          out_free, m_adv, m_free, hazard, issue;
    logic signed [ACC_W-1:0]       acc, quot;
    logic                          sat_hi, sat_lo;
    logic signed [SAMPLE_BITS-1:0] y;

    // Handshake between stages. An item may not enter the product stage while
    // the item ahead belongs to the same channel: its output is not yet in
    // the history.
    assign out_free = ~r_o_valid | ~i_out_stall;
    assign m_adv    = r_m_valid & out_free;
    assign m_free   = ~r_m_valid | m_adv;
    assign hazard   = r_m_valid & (r_m_chan == i_q_item.chan);
    assign issue    = i_q_valid & m_free & ~hazard;
    assign o_q_pop  = issue;
    assign n_o_valid = m_adv | (r_o_valid & i_out_stall);

    always_comb begin
        n_m_p0 = i_coefs.b0 * i_q_item.sample;
        n_m_p1 = i_coefs.b1 * r_in1[i_q_item.chan];
        n_m_p2 = i_coefs.b2 * r_in2[i_q_item.chan];
        n_m_p3 = i_coefs.a1 * r_out1[i_q_item.chan];
        n_m_p4 = i_coefs.a2 * r_out2[i_q_item.chan];
    end

    always_comb begin
        acc = ACC_W'(r_m_p0) + ACC_W'(r_m_p1) + ACC_W'(r_m_p2)
            - ACC_W'(r_m_p3) - ACC_W'(r_m_p4) + ROUND_BIAS;
        quot   = acc >>> FRAC_BITS;
        sat_hi = (quot > SAT_MAX_ACC);
        sat_lo = (quot < SAT_MIN_ACC);
        priority if (sat_hi) begin
            y = SMP_MAX;
        end else if (sat_lo) begin
            y = SMP_MIN;
        end else begin
            y = quot[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_in1[c]  <= '0;
                r_in2[c]  <= '0;
                r_out1[c] <= '0;
                r_out2[c] <= '0;
            end
        end else begin
            r_o_valid <= n_o_valid;
            if (m_free) begin
                r_m_valid <= issue;
            end
            if (m_adv) begin
                r_in2[r_m_chan]  <= r_in1[r_m_chan];
                r_in1[r_m_chan]  <= r_m_x;
                r_out2[r_m_chan] <= r_out1[r_m_chan];
                r_out1[r_m_chan] <= y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_m_chan <= i_q_item.chan;
            r_m_x    <= i_q_item.sample;
            r_m_p0   <= n_m_p0;
            r_m_p1   <= n_m_p1;
            r_m_p2   <= n_m_p2;
            r_m_p3   <= n_m_p3;
            r_m_p4   <= n_m_p4;
        end
        if (m_adv) begin
            r_o_sample <= y;
            r_o_clip   <= sat_hi | sat_lo;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_sample_out = r_o_sample;
    assign o_clipped    = r_o_clip;

endmodule

[rtl/core/bpf_checker.sv]
// Port-level assertions for the biquad peaking filter, bound to the top level.
module bpf_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic signed [bpf_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input logic                                   o_clipped
);
    import bpf_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_sample_out) && $stable(o_clipped))
        else $error("result changed while stalled");

    // a clipped result sits on a rail
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |-> (o_sample_out == SMP_MAX) || (o_sample_out == SMP_MIN))
        else $error("clip flag set off the rails");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // no result without an earlier input transaction
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && $past(i_rst_n) |->
            $past(i_in_valid && !o_in_stall, 2) || $past(o_in_stall, 2)
            || $past(o_out_valid, 2) || !$past(i_rst_n, 2)
            || $past(i_in_valid && !o_in_stall, 3) || $past(o_in_stall, 3))
        else $error("result without a source transaction");

endmodule

bind biquad_peaking_filter bpf_checker u_bpf_checker (.*);

[tb/tb_biquad_peaking_filter.sv]
// Self-checking testbench for the direct form I biquad peaking filter.
`timescale 1ns / 100ps

module tb_biquad_peaking_filter;
    import bpf_pkg::*;

    // Cycles without any transaction or register access before the watchdog
    // gives up. The longest legal gap is the receiver hold-off plus a drain.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES     = 150;
    localparam int IDLE_PERCENT    = 21;
    localparam int MAX_SHOWN       = 10;
    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_SAMPLES   = 225;
    localparam int STRETCH_SAMPLES = 250;
    localparam int HOLD_SAMPLES    = 60;

    // One filtered sample as it is expected on the result channel.
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clipped;
    } t_filt_out;

    logic                          i_clk;
    logic                          rst_n      = 1'b0;
    logic                          psel       = 1'b0;
    logic                          penable    = 1'b0;
    logic                          pwrite     = 1'b0;
    logic [ADDR_W-1:0]             paddr      = '0;
    logic [DATA_W-1:0]             pwdata     = '0;
    logic [DATA_W-1:0]             prdata;
    logic                          pready;
    logic                          in_valid   = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] in_sample  = '0;
    logic                          in_chan    = 1'b0;
    logic                          out_valid;
    logic                          out_stall  = 1'b0;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          out_clipped;

    // Shadow of the coefficient registers and of each channel's history.
    logic signed [COEF_W-1:0]      coef_q [REG_COUNT];
    logic signed [SAMPLE_BITS-1:0] x1_q [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] x2_q [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] y1_q [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] y2_q [CHANNELS];

    t_filt_out filtered_q [$];

    int  mismatch_count = 0;
    int  result_count   = 0;
    int  quiet_cycles   = 0;
    bit  idle_on        = 1'b1;  // random idling on both sides
    int  hold_requests  = 0;     // bumped by the test to start a receiver hold-off
    int  hold_served    = 0;
    int  hold_left      = 0;

    biquad_peaking_filter u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_sample_in  (in_sample),
        .i_chan       (in_chan),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_sample_out (out_sample),
        .o_clipped    (out_clipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: exact sum of the five products in 64 bits (each product is
    // below 2^55, so five of them plus the rounding bias cannot overflow),
    // round half up at the Q8.24 point, saturate, then shift the history of
    // the addressed channel with the saturated output.
    // ------------------------------------------------------------------
    function automatic void predict_sample(input logic signed [SAMPLE_BITS-1:0] x,
                                           input logic ch);
        int        c;
        longint    acc;
        longint    yq;
        t_filt_out r;
        c   = int'(ch) % CHANNELS;
        acc = longint'(coef_q[REG_B0]) * longint'(x)
            + longint'(coef_q[REG_B1]) * longint'(x1_q[c])
            + longint'(coef_q[REG_B2]) * longint'(x2_q[c])
            - longint'(coef_q[REG_A1]) * longint'(y1_q[c])
            - longint'(coef_q[REG_A2]) * longint'(y2_q[c]);
        acc = acc + (64'sd1 <<< (FRAC_BITS - 1));
        yq  = acc >>> FRAC_BITS;
        r.clipped = 1'b1;
        if (yq > longint'(SMP_MAX))
            r.sample = SMP_MAX;
        else if (yq < longint'(SMP_MIN))
            r.sample = SMP_MIN;
        else begin
            r.sample  = yq[SAMPLE_BITS-1:0];
            r.clipped = 1'b0;
        end
        x2_q[c] = x1_q[c];
        x1_q[c] = x;
        y2_q[c] = y1_q[c];
        y1_q[c] = r.sample;
        filtered_q.push_back(r);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return SAMPLE_BITS'(int'($urandom_range(512)) - 256);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // Any 32-bit coefficient; kind 0 is unrestricted, 1 a plausible
    // filter within +/-2.0, 2 one of the edge values.
    function automatic logic signed [COEF_W-1:0] pick_coef(input int kind);
        int unsigned sel;
        sel = $urandom_range(3);
        case (kind)
            1: return COEF_W'(int'($urandom_range(1 << 26)) - (1 << 25));
            2: begin
                case (sel)
                    0: return {1'b0, {(COEF_W-1){1'b1}}};
                    1: return {1'b1, {(COEF_W-1){1'b0}}};
                    2: return COEF_ZERO;
                    default: return -COEF_ONE;
                endcase
            end
            default: return COEF_W'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Register write: setup cycle, then access cycle until pready.
    // Only called while the filter is drained.
    // ------------------------------------------------------------------
    task automatic write_coef(input t_reg_idx idx, input logic signed [COEF_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        coef_q[idx] = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(input logic signed [COEF_W-1:0] b0, b1, b2, a1, a2);
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
    endtask

    // One input transaction; while idling is on, each cycle is idle with
    // the idle probability before the item is offered.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic ch);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid  <= 1'b1;
        in_sample <= smp;
        in_chan   <= ch;
        do @(posedge i_clk); while (in_stall);
        predict_sample(smp, ch);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_reset();
        rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        rst_n <= 1'b1;
        foreach (coef_q[i]) coef_q[i] = COEF_ZERO;
        coef_q[REG_B0] = COEF_ONE;
        for (int c = 0; c < CHANNELS; c++) begin
            x1_q[c] = '0;
            x2_q[c] = '0;
            y1_q[c] = '0;
            y2_q[c] = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset coefficients give a unity pass-through: field extremes on both channels.
    task automatic test_reset_passthrough();
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b1);
        send_sample('0, 1'b0);
        send_sample(SAMPLE_BITS'(-1), 1'b1);
        send_sample(SAMPLE_BITS'(1), 1'b0);
        wait_drained();
    endtask

    // b0 = 0.5 puts results on the half-LSB: ties must round toward plus infinity.
    task automatic test_rounding();
        write_all(COEF_ONE >>> 1, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        send_sample(SAMPLE_BITS'(1), 1'b0);
        send_sample(SAMPLE_BITS'(-1), 1'b0);
        send_sample(SAMPLE_BITS'(3), 1'b1);
        send_sample(SAMPLE_BITS'(-3), 1'b1);
        wait_drained();
    endtask

    // Clipping both ways, and the clipped value must be what feeds back.
    task automatic test_saturation();
        // y = x + y1: a full-scale input clips on the second sample, and a
        // zero input then returns the stored (saturated) output.
        write_all(COEF_ONE, COEF_ZERO, COEF_ZERO, -COEF_ONE, COEF_ZERO);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b1);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b1);
        send_sample('0, 1'b0);
        send_sample('0, 1'b1);
        wait_drained();
        // All taps at the register extremes, same channel back to back.
        write_all({1'b0, {(COEF_W-1){1'b1}}}, {1'b1, {(COEF_W-1){1'b0}}},
                  {1'b0, {(COEF_W-1){1'b1}}}, {1'b1, {(COEF_W-1){1'b0}}},
                  {1'b0, {(COEF_W-1){1'b1}}});
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SAMPLE_BITS'(1), 1'b1);
        wait_drained();
    endtask

    // Random samples under several coefficient sets; channels mostly
    // alternate (full rate) with runs on one channel (feedback-limited rate).
    task automatic test_random_phases();
        logic ch;
        ch = 1'b0;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_all(pick_coef(p % 3), pick_coef(p % 3), pick_coef(p % 3),
                      pick_coef(p % 3), pick_coef(p % 3));
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                if ($urandom_range(9) == 0)
                    ch = 1'($urandom());
                else if ($urandom_range(3) != 0)
                    ch = ~ch;
                send_sample(pick_sample(), ch);
            end
            wait_drained();
        end
    endtask

    // A long stretch with neither side idling.
    task automatic test_no_idle_stretch();
        idle_on = 1'b0;
        write_all(pick_coef(1), pick_coef(1), pick_coef(1), pick_coef(1), pick_coef(1));
        for (int n = 0; n < STRETCH_SAMPLES; n++)
            send_sample(pick_sample(), 1'($urandom()));
        wait_drained();
        idle_on = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering, so the input
    // queue fills and the filter must stall its input.
    task automatic test_output_hold();
        idle_on = 1'b0;
        hold_requests++;
        for (int n = 0; n < HOLD_SAMPLES; n++)
            send_sample(pick_sample(), n[0]);
        wait_drained();
        idle_on = 1'b1;
    endtask

    initial begin
        apply_reset();
        test_reset_passthrough();
        test_rounding();
        test_saturation();
        test_random_phases();
        test_no_idle_stretch();
        test_output_hold();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && filtered_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, or a counted hold-off when one is requested.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (idle_on && rst_n) begin
            out_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Result checker: every accepted transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_filt_out want;
        if (rst_n && out_valid && !out_stall) begin
            result_count++;
            if (filtered_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("ERROR: result %0d unexpected: sample %0d clip %0b",
                             result_count, out_sample, out_clipped);
            end else begin
                want = filtered_q.pop_front();
                if (out_sample !== want.sample || out_clipped !== want.clipped) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("ERROR: result %0d: expected %0d/%0b, got %0d/%0b",
                                 result_count, want.sample, want.clipped,
                                 out_sample, out_clipped);
                end
            end
        end
    end

    // Watchdog: any transaction or register access counts as progress.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

[files.f]
rtl/core/bpf_pkg.sv
rtl/core/bpf_regs.sv
rtl/core/bpf_front.sv
rtl/core/bpf_back.sv
rtl/core/biquad_peaking_filter.sv
rtl/core/bpf_checker.sv
tb/tb_biquad_peaking_filter.sv
